### rtl/alte_pkg.sv
// Shared constants, codes and types of the ordered list table engine.
package alte_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes carried on the op port.
    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_PREPEND = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_FIND    = 3'd3;
    localparam logic [2:0] OP_UPDATE  = 3'd4;
    localparam logic [2:0] OP_REMOVE  = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Index reported when nothing was found or done.
    localparam logic [4:0] NO_INDEX = 5'h1F;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_INS,
        CMD_UPD,
        CMD_DEL,
        CMD_FIND
    } cell_cmd_t;

    // Control group sent from the sequencer to the cells.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [CNT_W-1:0]   at;
        logic [CNT_W-1:0]   cnt;
        logic [31:0]        val;
    } cell_ctrl_t;

endpackage

### rtl/alte_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
module alte_cell
    import alte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   cell_idx,
    input  cell_ctrl_t         ctrl,
    input  logic [31:0]        lower_data,
    input  logic [31:0]        upper_data,
    output logic [31:0]        data,
    output logic               match
);

    logic [31:0]      data_reg;
    logic [31:0]      data_next;
    logic             match_reg;
    logic             match_next;
    logic [CNT_W-1:0] my_pos;
    logic [CNT_W-1:0] my_pos_plus;

    assign my_pos      = CNT_W'(cell_idx);
    assign my_pos_plus = my_pos + CNT_W'(1);

    // Pick this cell's next entry from the broadcast command.
    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctrl.cmd)
            CMD_INS:
            begin
                if (my_pos == ctrl.at)
                begin
                    data_next = ctrl.val;
                end
                else if ((my_pos > ctrl.at) && (my_pos <= ctrl.cnt))
                begin
                    data_next = lower_data;
                end
            end
            CMD_UPD:
            begin
                if (my_pos == ctrl.at)
                begin
                    data_next = ctrl.val;
                end
            end
            CMD_DEL:
            begin
                if ((my_pos >= ctrl.at) && (my_pos_plus < ctrl.cnt))
                begin
                    data_next = upper_data;
                end
            end
            CMD_FIND:
            begin
                match_next = (data_reg == ctrl.val) && (my_pos < ctrl.cnt);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // The entry itself needs no reset; the match flag does.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

### rtl/array_list_table_engine_top.sv
// Top level of the ordered list table engine: sequencer, count and row of cells.
//
// Usage: drive op, value and position and raise start; the beat is taken at a
// rising edge where start is high and busy is low. Every beat yields exactly
// one result, shown on index, status and count for one cycle while done is
// high. The receiver cannot stall; it must take each result when done is high.
// Append, prepend, insert, update, remove and unknown ops finish in the cycle
// they are taken, and the result appears in the next cycle; a new beat may be
// taken in every cycle. Find compares all cells in parallel in the cycle it
// is taken, registers one match flag per cell, and then runs the priority
// encoder over those flags in the S_FIND state, during which busy is high;
// its result is registered from that state. Throughput is thus one beat per
// cycle, except that a find holds off the next beat while busy is high; this
// stall is set by the match-flag register stage.
// Reset clears the entry count, the sequencer and done; the entries are
// stale until written and are never read past the count, so no clearing
// pass is needed and the block takes beats right after reset.
module array_list_table_engine_top
    import alte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    input  logic [POS_W-1:0]   position,
    output logic               done,
    output logic signed [4:0]  index,
    output logic [1:0]         status,
    output logic [4:0]         count
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIND = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    logic [4:0]       index_reg;
    logic [4:0]       index_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;

    logic             accept;
    logic             full;
    logic             pos_valid;
    logic [CNT_W-1:0] ins_at;
    cell_ctrl_t       ctrl;
    logic [31:0]      cell_data [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic             found;
    logic [IDX_W-1:0] found_idx;

    assign busy      = (state_reg == S_FIND);
    assign accept    = start && !busy;
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign pos_valid = (CMP_W'(position) < CMP_W'(count_reg));
    assign ins_at    = pos_valid ? CNT_W'(position) : count_reg;

    // First matching cell, lowest index wins.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
    end

    // Sequencer: decode the beat, drive the cells and form the result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        index_next  = index_reg;
        status_next = status_reg;
        ctrl.cmd    = CMD_NOP;
        ctrl.at     = '0;
        ctrl.cnt    = count_reg;
        ctrl.val    = value;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    index_next  = NO_INDEX;
                    status_next = ST_OK;
                    if ((op == OP_APPEND) || (op == OP_PREPEND) || (op == OP_INSERT))
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.cmd = CMD_INS;
                            if (op == OP_APPEND)
                            begin
                                ctrl.at = count_reg;
                            end
                            else if (op == OP_PREPEND)
                            begin
                                ctrl.at = '0;
                            end
                            else
                            begin
                                ctrl.at = ins_at;
                            end
                            count_next = count_reg + CNT_W'(1);
                            index_next = 5'(ctrl.at);
                        end
                    end
                    else if (op == OP_FIND)
                    begin
                        ctrl.cmd   = CMD_FIND;
                        done_next  = 1'b0;
                        state_next = S_FIND;
                    end
                    else if ((op == OP_UPDATE) || (op == OP_REMOVE))
                    begin
                        if (!pos_valid)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            ctrl.at    = CNT_W'(position);
                            index_next = 5'(position);
                            if (op == OP_UPDATE)
                            begin
                                ctrl.cmd = CMD_UPD;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_DEL;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        status_next = ST_BAD;
                    end
                end
            end
            S_FIND:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                index_next  = found ? 5'(found_idx) : NO_INDEX;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        index_reg  <= index_next;
        status_reg <= status_next;
    end

    // Row of cells; each one sees its lower and upper neighbor.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [31:0] lower_d;
        logic [31:0] upper_d;

        if (g == 0)
        begin : g_lo_edge
            assign lower_d = '0;
        end
        else
        begin : g_lo
            assign lower_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_hi_edge
            assign upper_d = '0;
        end
        else
        begin : g_hi
            assign upper_d = cell_data[g+1];
        end

        alte_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(g)),
            .ctrl       (ctrl),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    assign done   = done_reg;
    assign index  = index_reg;
    assign status = status_reg;
    assign count  = 5'(count_reg);

endmodule

### rtl/alte_checker.sv
// Port-level checks of the ordered list table engine and their binding.
module alte_checker
    import alte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    input  logic [POS_W-1:0]   position,
    input  logic               done,
    input  logic signed [4:0]  index,
    input  logic [1:0]         status,
    input  logic [4:0]         count
);

    // A find beat moves the block into its encode cycle.
    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_FIND)) |=> busy)
        else $error("find beat did not raise busy");

    // The encode cycle ends with a result, and busy is then low.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("find result missing after busy cycle");

    // Any non-find beat gives a result in the next cycle.
    a_beat_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_FIND)) |=> done)
        else $error("result missing after beat");

    // A rejected beat, full or bad, reports no index.
    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((status == ST_FULL) || (status == ST_BAD))) |-> (index == NO_INDEX))
        else $error("rejected beat reported an index");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("unused status code");

endmodule

bind array_list_table_engine_top alte_checker u_alte_checker (.*);

### verif/tb.sv
// Testbench of the ordered list table engine: directed and random beats checked against a predictor.
module tb
    import alte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes outside the defined set; the block must reject them.
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam int IDLE_LIMIT = 1000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [4:0] idx;
        logic [1:0] stat;
        logic [4:0] cnt;
    } list_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [2:0]          op;
    logic signed [31:0]  value;
    logic [POS_W-1:0]    position;
    logic                done;
    logic signed [4:0]   index;
    logic [1:0]          status;
    logic [4:0]          count;

    // Shadow copy of the list, updated as each beat is accepted.
    logic [31:0]         shadow_vals [DEPTH];
    int                  shadow_len;

    list_result_t        pending_results[$];
    int                  mismatches;
    int                  stray_results;
    int                  idle_cycles;
    int                  burst_left;

    array_list_table_engine_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .value    (value),
        .position (position),
        .done     (done),
        .index    (index),
        .status   (status),
        .count    (count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one operation to the shadow list and return the result it should give.
    function automatic list_result_t apply_list_op(logic [2:0] code, logic [31:0] val,
                                                   logic [4:0] pos);
        list_result_t res;
        int           at;
        bit           hit;
        res.idx = NO_INDEX;
        res.stat = ST_OK;
        hit = 1'b0;
        case (code)
            OP_APPEND, OP_PREPEND, OP_INSERT:
            begin
                if (shadow_len >= DEPTH)
                begin
                    res.stat = ST_FULL;
                end
                else
                begin
                    if (code == OP_APPEND)
                        at = shadow_len;
                    else if (code == OP_PREPEND)
                        at = 0;
                    else
                        at = (int'(pos) >= shadow_len) ? shadow_len : int'(pos);
                    for (int i = shadow_len; i > at; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[at] = val;
                    shadow_len++;
                    res.idx = at[4:0];
                end
            end
            OP_FIND:
            begin
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (!hit && shadow_vals[i] == val)
                    begin
                        hit = 1'b1;
                        res.idx = i[4:0];
                    end
                end
            end
            OP_UPDATE:
            begin
                if (int'(pos) >= shadow_len)
                begin
                    res.stat = ST_BAD;
                end
                else
                begin
                    shadow_vals[pos] = val;
                    res.idx = pos;
                end
            end
            OP_REMOVE:
            begin
                if (int'(pos) >= shadow_len)
                begin
                    res.stat = ST_BAD;
                end
                else
                begin
                    for (int i = int'(pos); i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                    res.idx = pos;
                end
            end
            default:
            begin
                res.stat = ST_BAD;
            end
        endcase
        res.cnt = shadow_len[4:0];
        return res;
    endfunction

    // Send one beat: sometimes pause first, then hold start until the block takes it.
    task automatic send_beat(logic [2:0] code, logic [31:0] val, logic [4:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        op <= code;
        value <= val;
        position <= pos;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_list_op(code, val, pos));
    endtask

    // Empty list: find misses, edits at position 0 fail, unknown ops are rejected.
    task automatic test_empty_list();
        send_beat(OP_FIND, 32'h0, 5'd0);
        send_beat(OP_UPDATE, 32'h1234_5678, 5'd0);
        send_beat(OP_REMOVE, 32'h0, 5'd0);
        send_beat(OP_RSVD_6, 32'hFFFF_FFFF, 5'd16);
        send_beat(OP_RSVD_7, 32'h8000_0000, 5'd1);
    endtask

    // Adds at head, tail and middle, hits and misses of find, good and bad edits.
    task automatic test_edit_ops();
        send_beat(OP_APPEND, 32'h7FFF_FFFF, 5'd0);
        send_beat(OP_PREPEND, 32'h8000_0000, 5'd9);
        send_beat(OP_INSERT, 32'h0000_0000, 5'd0);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 5'd16);
        send_beat(OP_INSERT, 32'h5A5A_5A5A, 5'd2);
        send_beat(OP_FIND, 32'h8000_0000, 5'd0);
        send_beat(OP_FIND, 32'hFFFF_FFFF, 5'd0);
        send_beat(OP_FIND, 32'h1234_5678, 5'd0);
        send_beat(OP_UPDATE, 32'hA5A5_A5A5, 5'd4);
        send_beat(OP_UPDATE, 32'h0000_0001, 5'd5);
        send_beat(OP_REMOVE, 32'h0, 5'd5);
        send_beat(OP_REMOVE, 32'h0, 5'd0);
        send_beat(OP_REMOVE, 32'h0, 5'd3);
    endtask

    // Fill the list, then check that adds are refused and the top slot still works.
    task automatic test_full_list();
        while (shadow_len < DEPTH)
            send_beat(OP_APPEND, $urandom, shadow_len[4:0]);
        send_beat(OP_APPEND, 32'h1111_1111, 5'd0);
        send_beat(OP_PREPEND, 32'h2222_2222, 5'd0);
        send_beat(OP_INSERT, 32'h3333_3333, 5'd3);
        send_beat(OP_FIND, shadow_vals[DEPTH-1], 5'd0);
        send_beat(OP_UPDATE, 32'hDEAD_0001, 5'(DEPTH - 1));
        send_beat(OP_REMOVE, 32'h0, 5'(DEPTH - 1));
        send_beat(OP_PREPEND, 32'hC0DE_0002, 5'd0);
        send_beat(OP_REMOVE, 32'h0, 5'd16);
    endtask

    // Random traffic that alternates between growing and shrinking the list.
    task automatic test_random_traffic(int beats);
        logic [2:0]  code;
        logic [31:0] val;
        logic [4:0]  pos;
        int          pick;
        bit          growing;
        for (int k = 0; k < beats; k++)
        begin
            growing = ((k / 48) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                code = ($urandom_range(0, 1) != 0) ? OP_RSVD_6 : OP_RSVD_7;
            else if (pick < (growing ? 23 : 11))
                code = OP_APPEND;
            else if (pick < (growing ? 38 : 17))
                code = OP_PREPEND;
            else if (pick < (growing ? 58 : 25))
                code = OP_INSERT;
            else if (pick < (growing ? 78 : 45))
                code = OP_FIND;
            else if (pick < (growing ? 90 : 57))
                code = OP_UPDATE;
            else
                code = OP_REMOVE;

            // Mostly valid positions, some anywhere from 0 to 16.
            if ($urandom_range(0, 3) != 0 && shadow_len > 0)
                pos = 5'($urandom_range(0, shadow_len - 1));
            else
                pos = 5'($urandom_range(0, 16));

            // Values from a small pool or the list itself give find something to hit.
            case ($urandom_range(0, 2))
                0: val = $urandom;
                1:
                begin
                    case ($urandom_range(0, 5))
                        0: val = 32'h0000_0000;
                        1: val = 32'hFFFF_FFFF;
                        2: val = 32'h8000_0000;
                        3: val = 32'h7FFF_FFFF;
                        4: val = 32'h5555_5555;
                        default: val = 32'hAAAA_AAAA;
                    endcase
                end
                default:
                begin
                    if (shadow_len > 0)
                        val = shadow_vals[$urandom_range(0, shadow_len - 1)];
                    else
                        val = $urandom;
                end
            endcase
            send_beat(code, val, pos);
        end
    endtask

    // Each result must match the oldest outstanding expectation.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                stray_results++;
                if (mismatches + stray_results <= MAX_SHOWN)
                    $display("%0t: result with nothing expected: index %0d status %0d count %0d",
                             $realtime, index, status, count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (index !== want.idx || status !== want.stat || count !== want.cnt)
                begin
                    mismatches++;
                    if (mismatches + stray_results <= MAX_SHOWN)
                        $display("%0t: expected index %0d status %0d count %0d, got %0d %0d %0d",
                                 $realtime, $signed(want.idx), want.stat, want.cnt,
                                 index, status, count);
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat or result ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_APPEND;
        value = '0;
        position = '0;
        shadow_len = 0;
        mismatches = 0;
        stray_results = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_vals[i] = '0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_edit_ops();
        test_full_list();
        test_random_traffic(610);

        // Drain: stop sending and let the last results come back.
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && stray_results == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
